/* hw/rtl/spq_pkg.sv */
// Package of the sorted priority queue: operation and status codes,
// the stored entry and result types and the controller states.
// Depends on nothing; spq_mem, the top level and the testbench use it.
package spq_pkg;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_LIST   = 2'd2;

	typedef enum logic [2:0] {
		ST_ENQ   = 3'd0,
		ST_DEQ   = 3'd1,
		ST_EMPTY = 3'd2,
		ST_FULL  = 3'd3,
		ST_LIST  = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0]         id;
		logic signed [31:0] prio;
	} entry_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         id;
		logic signed [31:0] prio;
		logic               last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_PUT,
		S_DEQ,
		S_LIST
	} state_t;

endpackage

/* hw/rtl/spq_if.sv */
// Channel interfaces of the sorted priority queue: the request channel
// and the result channel, each with valid, ready and its payload.
// Depends on nothing.
interface spq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [7:0]         proc_id;
	logic signed [31:0] prio;

	modport source (output valid, output func, output proc_id, output prio, input ready);
	modport sink (input valid, input func, input proc_id, input prio, output ready);
endinterface

interface spq_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [7:0]         out_id;
	logic signed [31:0] out_prio;
	logic               last;

	modport source (output valid, output status, output out_id, output out_prio,
		output last, input ready);
	modport sink (input valid, input status, input out_id, input out_prio,
		input last, output ready);
endinterface

/* hw/rtl/spq_mem.sv */
// Entry store of the sorted priority queue: one write and one read port,
// read data registered, appearing in the cycle after the read enable.
// Depends on spq_pkg for the entry type.
module spq_mem #(
	parameter int DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  spq_pkg::entry_t            wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output spq_pkg::entry_t            rdata
);

	spq_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/sorted_priority_queue_unit.sv */
// Top level of the sorted priority queue: controller, circular entry
// store and result register. Depends on spq_pkg, spq_if and spq_mem.
//
// Usage. Requests arrive on req (func, proc_id, prio), results leave on
// rsp (status, out_id, out_prio, last); a beat moves when valid and ready
// are both high. Entries sit in one memory as a circular list from the
// head, sorted by descending priority, so a remove only moves the head.
// A request is taken only while the controller is idle and the result
// register is free or being emptied in the same cycle.
// Add: the result is registered and appears in the cycle after the beat;
// the controller then shifts entries from the tail towards the insertion
// point, one entry per cycle through the memory read and write ports. A
// rejected add, or any request on an empty queue, gives its result in the
// cycle after the beat and leaves the block idle. Remove: the head entry
// is read from the memory and then loaded into the result register.
// List: one result per cycle while the receiver takes them, the last
// flagged. When the receiver stalls, the result register holds and the
// controller waits to load its next result. Reset empties the queue; the
// memory contents need no clearing.
module sorted_priority_queue_unit #(
	parameter int CAPACITY = 32
) (
	input logic     clk,
	input logic     arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_A = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	spq_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   head_q, head_d;
	logic [AW-1:0]   idx_q, idx_d;
	spq_pkg::entry_t new_q, new_d;
	logic            rsp_valid_q;
	spq_pkg::rsp_t   rsp_q, rsp_d;
	logic            rsp_load;
	logic            out_free;

	logic            mem_we, mem_re;
	logic [AW-1:0]   wlog, rlog;
	logic [AW-1:0]   waddr, raddr;
	spq_pkg::entry_t wdata, rdata;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= CAP_A) begin
			s = s - CAP_A;
		end
		return s[AW-1:0];
	endfunction

	assign out_free = !rsp_valid_q || rsp.ready;
	assign waddr    = wrap_add(head_q, wlog);
	assign raddr    = wrap_add(head_q, rlog);

	spq_mem #(.DEPTH(CAPACITY)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		head_d    = head_q;
		idx_d     = idx_q;
		new_d     = new_q;
		rsp_load  = 1'b0;
		rsp_d     = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		wlog      = '0;
		rlog      = '0;
		wdata     = new_q;
		req.ready = 1'b0;
		case (state_q)
			spq_pkg::S_IDLE: begin
				req.ready = out_free;
				if (req.valid && out_free) begin
					case (req.func)
						spq_pkg::FUNC_ADD: begin
							rsp_load   = 1'b1;
							rsp_d.id   = req.proc_id;
							rsp_d.prio = req.prio;
							rsp_d.last = 1'b1;
							if (count_q == CAP_C) begin
								rsp_d.status = spq_pkg::ST_FULL;
							end else begin
								rsp_d.status = spq_pkg::ST_ENQ;
								count_d      = count_q + CW'(1);
								new_d.id     = req.proc_id;
								new_d.prio   = req.prio;
								if (count_q == '0) begin
									mem_we     = 1'b1;
									wdata.id   = req.proc_id;
									wdata.prio = req.prio;
								end else begin
									mem_re  = 1'b1;
									rlog    = AW'(count_q - CW'(1));
									idx_d   = AW'(count_q - CW'(1));
									state_d = spq_pkg::S_INS;
								end
							end
						end
						spq_pkg::FUNC_REMOVE: begin
							if (count_q == '0) begin
								rsp_load     = 1'b1;
								rsp_d.status = spq_pkg::ST_EMPTY;
								rsp_d.last   = 1'b1;
							end else begin
								mem_re  = 1'b1;
								head_d  = wrap_add(head_q, AW'(1));
								count_d = count_q - CW'(1);
								state_d = spq_pkg::S_DEQ;
							end
						end
						spq_pkg::FUNC_LIST: begin
							if (count_q == '0) begin
								rsp_load     = 1'b1;
								rsp_d.status = spq_pkg::ST_EMPTY;
								rsp_d.last   = 1'b1;
							end else begin
								mem_re  = 1'b1;
								idx_d   = '0;
								state_d = spq_pkg::S_LIST;
							end
						end
						default: begin
						end
					endcase
				end
			end
			spq_pkg::S_INS: begin
				mem_we = 1'b1;
				wlog   = idx_q + AW'(1);
				if (idx_q != '0) begin
					if (rdata.prio > new_q.prio) begin
						state_d = spq_pkg::S_IDLE;
					end else begin
						wdata  = rdata;
						mem_re = 1'b1;
						rlog   = idx_q - AW'(1);
						idx_d  = idx_q - AW'(1);
					end
				end else if (rdata.prio < new_q.prio) begin
					wdata   = rdata;
					state_d = spq_pkg::S_PUT;
				end else begin
					state_d = spq_pkg::S_IDLE;
				end
			end
			spq_pkg::S_PUT: begin
				mem_we  = 1'b1;
				state_d = spq_pkg::S_IDLE;
			end
			spq_pkg::S_DEQ: begin
				if (out_free) begin
					rsp_load     = 1'b1;
					rsp_d.status = spq_pkg::ST_DEQ;
					rsp_d.id     = rdata.id;
					rsp_d.prio   = rdata.prio;
					rsp_d.last   = 1'b1;
					state_d      = spq_pkg::S_IDLE;
				end
			end
			spq_pkg::S_LIST: begin
				if (out_free) begin
					rsp_load     = 1'b1;
					rsp_d.status = spq_pkg::ST_LIST;
					rsp_d.id     = rdata.id;
					rsp_d.prio   = rdata.prio;
					rsp_d.last   = (CW'(idx_q) + CW'(1)) == count_q;
					if (rsp_d.last) begin
						state_d = spq_pkg::S_IDLE;
					end else begin
						mem_re = 1'b1;
						rlog   = idx_q + AW'(1);
						idx_d  = idx_q + AW'(1);
					end
				end
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			head_q  <= head_d;
			idx_q   <= idx_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		new_q <= new_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_q.status;
	assign rsp.out_id   = rsp_q.id;
	assign rsp.out_prio = rsp_q.prio;
	assign rsp.last     = rsp_q.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("Entry count exceeds capacity.");

	a_ins_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spq_pkg::S_INS) |-> (CW'(idx_q) + CW'(1) < count_q))
		else $error("Insertion index outside the stored entries.");

	a_list_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spq_pkg::S_LIST) |-> (CW'(idx_q) < count_q))
		else $error("List index outside the stored entries.");

	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.func == spq_pkg::FUNC_ADD && count_q == CAP_C)
		|=> ($stable(count_q) && state_q == spq_pkg::S_IDLE))
		else $error("Rejected add changed the queue.");

endmodule

/* tb/sv/tb_sorted_priority_queue_unit.sv */
// Self-checking testbench of sorted_priority_queue_unit: directed and random add,
// remove and list beats, checked against a mirror of the sorted entry list.
// Depends on spq_pkg, spq_if and the RTL of the block.
module tb_sorted_priority_queue_unit;

	localparam int         CAPACITY      = 32;
	localparam logic [1:0] FUNC_UNUSED   = 2'd3;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         DRAIN_CYCLES  = 60;
	localparam int         CYCLE_LIMIT   = 500000;
	localparam int         RANDOM_ITEMS  = 6;

	class sorted_queue_mirror;
		int              capacity;
		int              failures;
		spq_pkg::entry_t stored[$];
		spq_pkg::rsp_t   pending_results[$];

		function new(int cap);
			capacity = cap;
			failures = 0;
		endfunction

		function void push_result(spq_pkg::status_t st, logic [7:0] id,
			logic signed [31:0] p, logic l);
			spq_pkg::rsp_t r;
			r.status = st;
			r.id     = id;
			r.prio   = p;
			r.last   = l;
			pending_results.push_back(r);
		endfunction

		function void note_request(logic [1:0] func, logic [7:0] id, logic signed [31:0] p);
			spq_pkg::entry_t e;
			int              pos;
			e.id   = id;
			e.prio = p;
			case (func)
				spq_pkg::FUNC_ADD: begin
					if (stored.size() >= capacity) begin
						push_result(spq_pkg::ST_FULL, id, p, 1'b1);
					end else begin
						pos = 0;
						if (stored.size() != 0 && !($signed(stored[0].prio) < p)) begin
							pos = 1;
							while (pos < stored.size() && $signed(stored[pos].prio) > p)
								pos++;
						end
						stored.insert(pos, e);
						push_result(spq_pkg::ST_ENQ, id, p, 1'b1);
					end
				end
				spq_pkg::FUNC_REMOVE: begin
					if (stored.size() == 0) begin
						push_result(spq_pkg::ST_EMPTY, 8'd0, 32'sd0, 1'b1);
					end else begin
						e = stored.pop_front();
						push_result(spq_pkg::ST_DEQ, e.id, e.prio, 1'b1);
					end
				end
				spq_pkg::FUNC_LIST: begin
					if (stored.size() == 0) begin
						push_result(spq_pkg::ST_EMPTY, 8'd0, 32'sd0, 1'b1);
					end else begin
						foreach (stored[i])
							push_result(spq_pkg::ST_LIST, stored[i].id, stored[i].prio,
								i == stored.size() - 1);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [2:0] st, logic [7:0] id, logic signed [31:0] p,
			logic l);
			spq_pkg::rsp_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: status %0d id %0d prio %0d last %0b",
					st, id, p, l);
				failures++;
				return;
			end
			want = pending_results.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				failures++;
			end
			if (id !== want.id) begin
				$error("out_id: expected %0d, actual %0d", want.id, id);
				failures++;
			end
			if (p !== want.prio) begin
				$error("out_prio: expected %0d, actual %0d", want.prio, p);
				failures++;
			end
			if (l !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, l);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_requests;
	int   hold_served;
	int   hold_left;
	int   cycle_count;

	sorted_queue_mirror mirror;

	spq_req_if req();
	spq_rsp_if rsp();

	sorted_priority_queue_unit #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_sorted_priority_queue_unit: FAIL");
			$finish;
		end
	end

	// The receiver checks each result beat and decides its ready for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				mirror.check_result(rsp.status, rsp.out_id, rsp.out_prio, rsp.last);
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp.ready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_left   <= HOLD_CYCLES;
				hold_served <= hold_served + 1;
				rsp.ready   <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic signed [31:0] random_prio();
		case ($urandom_range(5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return $urandom_range(7);
			3: return -$signed(32'($urandom_range(7)));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(input logic [1:0] func, input logic [7:0] id,
		input logic signed [31:0] p);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid   <= 1'b1;
		req.func    <= func;
		req.proc_id <= id;
		req.prio    <= p;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		mirror.note_request(func, id, p);
	endtask

	task automatic run_random(input int n_items);
		int         sent;
		int         r;
		logic [1:0] func;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (sent < n_items / 2)
				func = (r < 68) ? spq_pkg::FUNC_ADD : (r < 88) ? spq_pkg::FUNC_REMOVE :
					(r < 97) ? spq_pkg::FUNC_LIST : FUNC_UNUSED;
			else
				func = (r < 25) ? spq_pkg::FUNC_ADD : (r < 85) ? spq_pkg::FUNC_REMOVE :
					(r < 97) ? spq_pkg::FUNC_LIST : FUNC_UNUSED;
			send_request(func, 8'($urandom_range(255)), random_prio());
			if (func != FUNC_UNUSED)
				sent++;
		end
	endtask

	initial begin
		mirror        = new(CAPACITY);
		clk           = 1'b0;
		arst_n        = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 0;
		hold_served   = 0;
		hold_left     = 0;
		cycle_count   = 0;
		req.valid     = 1'b0;
		req.func      = spq_pkg::FUNC_ADD;
		req.proc_id   = 8'd0;
		req.prio      = 32'sd0;
		rsp.ready     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(spq_pkg::FUNC_LIST, 8'd0, 32'sd0);
		send_request(spq_pkg::FUNC_REMOVE, 8'd0, 32'sd0);
		send_request(spq_pkg::FUNC_ADD, 8'h00, 32'sd0);
		send_request(spq_pkg::FUNC_ADD, 8'hff, 32'sh7fff_ffff);
		send_request(spq_pkg::FUNC_ADD, 8'h55, 32'sh8000_0000);
		send_request(spq_pkg::FUNC_ADD, 8'haa, 32'sh7fff_ffff);
		send_request(spq_pkg::FUNC_ADD, 8'h0f, -32'sd1);
		send_request(spq_pkg::FUNC_ADD, 8'hf0, 32'sd0);
		send_request(FUNC_UNUSED, 8'hff, 32'sh7fff_ffff);
		send_request(spq_pkg::FUNC_ADD, 8'h3c, 32'sh8000_0000);
		send_request(spq_pkg::FUNC_LIST, 8'hff, -32'sd1);
		send_request(spq_pkg::FUNC_REMOVE, 8'd0, 32'sd0);
		send_request(spq_pkg::FUNC_REMOVE, 8'd0, 32'sd0);
		send_request(spq_pkg::FUNC_LIST, 8'd0, 32'sd0);
		repeat (5) send_request(spq_pkg::FUNC_REMOVE, 8'd0, 32'sd0);
		send_request(spq_pkg::FUNC_REMOVE, 8'd0, 32'sd0);
		send_request(spq_pkg::FUNC_LIST, 8'd0, 32'sd0);

		// The receiver holds off, so the request channel stalls; the add beats,
		// more than the capacity, then fill the queue and make it overflow.
		hold_requests = hold_requests + 1;
		repeat (CAPACITY + 4)
			send_request(spq_pkg::FUNC_ADD, 8'($urandom_range(255)), random_prio());
		send_request(spq_pkg::FUNC_LIST, 8'd0, 32'sd0);
		repeat (CAPACITY + 2)
			send_request(spq_pkg::FUNC_REMOVE, 8'($urandom_range(255)), $urandom);

		send_idle_pct = 35;
		recv_idle_pct = 84;
		run_random(RANDOM_ITEMS);
		send_idle_pct = 84;
		recv_idle_pct = 35;
		run_random(RANDOM_ITEMS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(RANDOM_ITEMS);
		req.valid <= 1'b0;

		while (mirror.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.failures == 0 && mirror.pending_results.size() == 0)
			$display("tb_sorted_priority_queue_unit: PASS");
		else
			$display("tb_sorted_priority_queue_unit: FAIL");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_mem.sv
hw/rtl/sorted_priority_queue_unit.sv
tb/sv/tb_sorted_priority_queue_unit.sv
